// ===== rtl/line_segment_window_clipper_defines.svh =====
// ---------------------------------------------------------------------------
// Line segment window clipper assertion macros
// Concurrent assertion shorthands for the clipper top level.
// ---------------------------------------------------------------------------
`ifndef LINE_SEGMENT_WINDOW_CLIPPER_DEFINES_SVH
`define LINE_SEGMENT_WINDOW_CLIPPER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define LSWC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define LSWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lswc_pkg.sv =====
// ---------------------------------------------------------------------------
// Line segment window clipper package
// Outcode bits, register map, reset values and state encodings.
// ---------------------------------------------------------------------------
package lswc_pkg;

    typedef logic [3:0] code_t;

    localparam code_t CODE_LEFT  = 4'b0001;
    localparam code_t CODE_RIGHT = 4'b0010;
    localparam code_t CODE_BELOW = 4'b0100;
    localparam code_t CODE_ABOVE = 4'b1000;

    localparam int MAX_STEPS = 8;
    localparam int STEP_BITS = 4;
    typedef logic [STEP_BITS-1:0] step_t;

    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    localparam int RST_LEFT   = 150;
    localparam int RST_BOTTOM = 100;
    localparam int RST_RIGHT  = 450;
    localparam int RST_TOP    = 400;

    typedef enum logic [1:0] {
        REG_LEFT,
        REG_BOTTOM,
        REG_RIGHT,
        REG_TOP
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CODE,
        ST_SETUP,
        ST_ARITH,
        ST_UPDATE,
        ST_FINISH
    } core_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_phase_t;

endpackage

// ===== rtl/lswc_if.sv =====
// ---------------------------------------------------------------------------
// Line segment window clipper channels
// Segment input channel and clip result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface lswc_seg_if #(parameter int W = 12);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] start_x;
    logic signed [W-1:0] start_y;
    logic signed [W-1:0] end_x;
    logic signed [W-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lswc_res_if #(parameter int W = 12);
    logic                valid;
    logic                ready;
    logic                visible;
    logic signed [W-1:0] clipped_start_x;
    logic signed [W-1:0] clipped_start_y;
    logic signed [W-1:0] clipped_end_x;
    logic signed [W-1:0] clipped_end_y;

    modport source (output valid, visible, clipped_start_x, clipped_start_y,
                    clipped_end_x, clipped_end_y, input ready);
    modport sink   (input valid, visible, clipped_start_x, clipped_start_y,
                    clipped_end_x, clipped_end_y, output ready);
endinterface

// ===== rtl/lswc_cfg.sv =====
// ---------------------------------------------------------------------------
// Clipper window registers
// APB-style register file holding the four window bounds.
// ---------------------------------------------------------------------------
module lswc_cfg
    import lswc_pkg::*;
#(
    parameter int W = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output logic [W-2:0]         win_left,
    output logic [W-2:0]         win_bottom,
    output logic [W-2:0]         win_right,
    output logic [W-2:0]         win_top
);

    logic [W-2:0] left_reg, left_next;
    logic [W-2:0] bottom_reg, bottom_next;
    logic [W-2:0] right_reg, right_next;
    logic [W-2:0] top_reg, top_next;
    logic         wr_en;
    reg_idx_t     idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;

    always_comb
    begin
        left_next   = left_reg;
        bottom_next = bottom_reg;
        right_next  = right_reg;
        top_next    = top_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_LEFT:   left_next   = pwdata[W-2:0];
                REG_BOTTOM: bottom_next = pwdata[W-2:0];
                REG_RIGHT:  right_next  = pwdata[W-2:0];
                REG_TOP:    top_next    = pwdata[W-2:0];
                default:    left_next   = left_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_LEFT:   prdata = DATA_BITS'(left_reg);
            REG_BOTTOM: prdata = DATA_BITS'(bottom_reg);
            REG_RIGHT:  prdata = DATA_BITS'(right_reg);
            REG_TOP:    prdata = DATA_BITS'(top_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= (W-1)'(RST_LEFT);
            bottom_reg <= (W-1)'(RST_BOTTOM);
            right_reg  <= (W-1)'(RST_RIGHT);
            top_reg    <= (W-1)'(RST_TOP);
        end
        else
        begin
            left_reg   <= left_next;
            bottom_reg <= bottom_next;
            right_reg  <= right_next;
            top_reg    <= top_next;
        end
    end

    assign win_left   = left_reg;
    assign win_bottom = bottom_reg;
    assign win_right  = right_reg;
    assign win_top    = top_reg;

endmodule

// ===== rtl/lswc_muldiv.sv =====
// ---------------------------------------------------------------------------
// Clipper serial multiply-divide unit
// Bit-serial shift-add multiply then restoring divide, one bit per cycle.
// ---------------------------------------------------------------------------
module lswc_muldiv
    import lswc_pkg::*;
#(
    parameter int W = 12
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] mcand,
    input  logic [W-1:0] mplier,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quot
);

    localparam int CW = $clog2(W);

    md_phase_t      phase_reg, phase_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           done_reg, done_next;
    logic [2*W-1:0] prod_reg, prod_next;
    logic [W-1:0]   mcand_reg, mcand_next;
    logic [W-1:0]   div_reg, div_next;
    logic [W:0]     add_sum;
    logic [W:0]     rem_top;
    logic [W:0]     rem_sub;
    logic           q_bit;
    logic           last;

    always_comb
    begin
        add_sum = {1'b0, prod_reg[2*W-1:W]} + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        rem_top = {prod_reg[2*W-1:W], prod_reg[W-1]};
        rem_sub = rem_top - {1'b0, div_reg};
        q_bit   = (rem_top >= {1'b0, div_reg});
        last    = (cnt_reg == CW'(W-1));

        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        div_next   = div_reg;

        unique case (phase_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    prod_next  = {{W{1'b0}}, mplier};
                    mcand_next = mcand;
                    div_next   = divisor;
                    cnt_next   = '0;
                    phase_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                prod_next = {add_sum, prod_reg[W-1:1]};
                cnt_next  = last ? '0 : cnt_reg + CW'(1);
                if (last)
                begin
                    phase_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                prod_next = {(q_bit ? rem_sub[W-1:0] : rem_top[W-1:0]),
                             prod_reg[W-2:0], q_bit};
                cnt_next  = last ? '0 : cnt_reg + CW'(1);
                if (last)
                begin
                    phase_next = MD_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                phase_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MD_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
        div_reg   <= div_next;
    end

    assign done = done_reg;
    assign quot = prod_reg[W-1:0];

endmodule

// ===== rtl/lswc_core.sv =====
// ---------------------------------------------------------------------------
// Clipper control core
// Outcode test, edge selection and endpoint update sequencer.
// ---------------------------------------------------------------------------
module lswc_core
    import lswc_pkg::*;
#(
    parameter int W = 12
)
(
    input  logic         clk,
    input  logic         rst_n,
    lswc_seg_if.sink     seg,
    lswc_res_if.source   res,
    input  logic [W-2:0] win_left,
    input  logic [W-2:0] win_bottom,
    input  logic [W-2:0] win_right,
    input  logic [W-2:0] win_top,
    output logic         md_start,
    output logic [W-1:0] md_mcand,
    output logic [W-1:0] md_mplier,
    output logic [W-1:0] md_divisor,
    input  logic         md_done,
    input  logic [W-1:0] md_quot
);

    function automatic code_t outcode(input logic signed [W-1:0] x, y, l, b, r, t);
        code_t c;
        c = '0;
        if (x < l) c = c | CODE_LEFT;
        if (x > r) c = c | CODE_RIGHT;
        if (y < b) c = c | CODE_BELOW;
        if (y > t) c = c | CODE_ABOVE;
        return c;
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [W:0] v);
        logic [W:0] n;
        n = -v;
        return v[W] ? n[W-1:0] : v[W-1:0];
    endfunction

    core_state_t         state_reg, state_next;
    logic signed [W-1:0] x0_reg, x0_next, y0_reg, y0_next;
    logic signed [W-1:0] x1_reg, x1_next, y1_reg, y1_next;
    step_t               step_reg, step_next;
    code_t               cut_reg, cut_next;
    logic                move0_reg, move0_next;
    logic                neg_reg, neg_next;
    logic                accept_reg, accept_next;
    logic                res_valid_reg, res_valid_next;
    logic                vis_reg, vis_next;
    logic signed [W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [W-1:0] ex_reg, ex_next, ey_reg, ey_next;

    logic signed [W-1:0] wl, wb, wr, wt;
    code_t               c0, c1, csel;
    logic                win_bad;
    logic                y_edge;
    logic signed [W-1:0] a0, a1, b0, b1, bound;
    logic signed [W:0]   diff_a, diff_e, diff_d;
    logic signed [W-1:0] q_signed, new_c, nx, ny;
    logic                out_free;

    assign wl = $signed({1'b0, win_left});
    assign wb = $signed({1'b0, win_bottom});
    assign wr = $signed({1'b0, win_right});
    assign wt = $signed({1'b0, win_top});

    assign c0      = outcode(x0_reg, y0_reg, wl, wb, wr, wt);
    assign c1      = outcode(x1_reg, y1_reg, wl, wb, wr, wt);
    assign csel    = (c0 != '0) ? c0 : c1;
    assign win_bad = (win_left > win_right) || (win_bottom > win_top);

    assign y_edge = (cut_reg == CODE_ABOVE) || (cut_reg == CODE_BELOW);
    assign a0     = y_edge ? x0_reg : y0_reg;
    assign a1     = y_edge ? x1_reg : y1_reg;
    assign b0     = y_edge ? y0_reg : x0_reg;
    assign b1     = y_edge ? y1_reg : x1_reg;

    always_comb
    begin
        priority if (cut_reg == CODE_ABOVE) bound = wt;
        else if (cut_reg == CODE_BELOW)     bound = wb;
        else if (cut_reg == CODE_RIGHT)     bound = wr;
        else                                bound = wl;
    end

    assign diff_a = $signed({a1[W-1], a1}) - $signed({a0[W-1], a0});
    assign diff_e = $signed({bound[W-1], bound}) - $signed({b0[W-1], b0});
    assign diff_d = $signed({b1[W-1], b1}) - $signed({b0[W-1], b0});

    assign md_mcand   = mag(diff_a);
    assign md_mplier  = mag(diff_e);
    assign md_divisor = mag(diff_d);

    assign q_signed = neg_reg ? -$signed(md_quot) : $signed(md_quot);
    assign new_c    = a0 + q_signed;
    assign nx       = y_edge ? new_c : bound;
    assign ny       = y_edge ? bound : new_c;

    assign out_free = !res_valid_reg || res.ready;

    always_comb
    begin
        state_next     = state_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        x1_next        = x1_reg;
        y1_next        = y1_reg;
        step_next      = step_reg;
        cut_next       = cut_reg;
        move0_next     = move0_reg;
        neg_next       = neg_reg;
        accept_next    = accept_reg;
        res_valid_next = res_valid_reg && !res.ready;
        vis_next       = vis_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        md_start       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (seg.valid)
                begin
                    x0_next    = seg.start_x;
                    y0_next    = seg.start_y;
                    x1_next    = seg.end_x;
                    y1_next    = seg.end_y;
                    step_next  = '0;
                    state_next = ST_CODE;
                end
            end
            ST_CODE:
            begin
                priority if (win_bad || (step_reg == step_t'(MAX_STEPS)))
                begin
                    accept_next = 1'b0;
                    state_next  = ST_FINISH;
                end
                else if ((c0 | c1) == '0)
                begin
                    accept_next = 1'b1;
                    state_next  = ST_FINISH;
                end
                else if ((c0 & c1) != '0)
                begin
                    accept_next = 1'b0;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    priority if ((csel & CODE_ABOVE) != '0) cut_next = CODE_ABOVE;
                    else if ((csel & CODE_BELOW) != '0)     cut_next = CODE_BELOW;
                    else if ((csel & CODE_RIGHT) != '0)     cut_next = CODE_RIGHT;
                    else                                    cut_next = CODE_LEFT;
                    move0_next = (c0 != '0);
                    step_next  = step_reg + step_t'(1);
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (diff_d == '0)
                begin
                    accept_next = 1'b0;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    md_start   = 1'b1;
                    neg_next   = diff_a[W] ^ diff_e[W] ^ diff_d[W];
                    state_next = ST_ARITH;
                end
            end
            ST_ARITH:
            begin
                if (md_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (move0_reg)
                begin
                    x0_next = nx;
                    y0_next = ny;
                end
                else
                begin
                    x1_next = nx;
                    y1_next = ny;
                end
                state_next = ST_CODE;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    vis_next       = accept_reg;
                    sx_next        = accept_reg ? x0_reg : '0;
                    sy_next        = accept_reg ? y0_reg : '0;
                    ex_next        = accept_reg ? x1_reg : '0;
                    ey_next        = accept_reg ? y1_reg : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg     <= x0_next;
        y0_reg     <= y0_next;
        x1_reg     <= x1_next;
        y1_reg     <= y1_next;
        step_reg   <= step_next;
        cut_reg    <= cut_next;
        move0_reg  <= move0_next;
        neg_reg    <= neg_next;
        accept_reg <= accept_next;
        vis_reg    <= vis_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        ex_reg     <= ex_next;
        ey_reg     <= ey_next;
    end

    assign seg.ready           = (state_reg == ST_IDLE);
    assign res.valid           = res_valid_reg;
    assign res.visible         = vis_reg;
    assign res.clipped_start_x = sx_reg;
    assign res.clipped_start_y = sy_reg;
    assign res.clipped_end_x   = ex_reg;
    assign res.clipped_end_y   = ey_reg;

endmodule

// ===== rtl/line_segment_window_clipper.sv =====
// ---------------------------------------------------------------------------
// Line segment window clipper
// Clips one segment per beat against the window held in four APB registers.
// seg carries a segment (start_x/y, end_x/y); res returns visible and the
// clipped endpoints, zeros when the segment is rejected.
// Each edge clip (0 to 4 for a sane window, at most 8) runs the serial
// multiply-divide unit: shift-add multiply, then restoring divide, with
// outcode, setup, done handoff and endpoint update steps around it; a
// trivially accepted or rejected segment needs no clip.
// One segment is in flight at a time; the next beat is taken as soon as the
// result sits in the output register, even while res is stalled. A stalled
// res holds its beat; the core then waits with its next result.
// Reset clears the channels and loads the window 150..450 by 100..400.
// ---------------------------------------------------------------------------
`include "line_segment_window_clipper_defines.svh"

module line_segment_window_clipper
    import lswc_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    lswc_seg_if.sink             seg,
    lswc_res_if.source           res,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    logic [COORD_BITS-2:0] win_left;
    logic [COORD_BITS-2:0] win_bottom;
    logic [COORD_BITS-2:0] win_right;
    logic [COORD_BITS-2:0] win_top;
    logic                  md_start;
    logic                  md_done;
    logic [COORD_BITS-1:0] md_mcand;
    logic [COORD_BITS-1:0] md_mplier;
    logic [COORD_BITS-1:0] md_divisor;
    logic [COORD_BITS-1:0] md_quot;
    logic                  rej_zero;

    lswc_cfg #(.W(COORD_BITS)) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .win_left   (win_left),
        .win_bottom (win_bottom),
        .win_right  (win_right),
        .win_top    (win_top)
    );

    lswc_muldiv #(.W(COORD_BITS)) u_muldiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (md_start),
        .mcand   (md_mcand),
        .mplier  (md_mplier),
        .divisor (md_divisor),
        .done    (md_done),
        .quot    (md_quot)
    );

    lswc_core #(.W(COORD_BITS)) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .seg        (seg),
        .res        (res),
        .win_left   (win_left),
        .win_bottom (win_bottom),
        .win_right  (win_right),
        .win_top    (win_top),
        .md_start   (md_start),
        .md_mcand   (md_mcand),
        .md_mplier  (md_mplier),
        .md_divisor (md_divisor),
        .md_done    (md_done),
        .md_quot    (md_quot)
    );

    assign rej_zero = (res.clipped_start_x == '0) && (res.clipped_start_y == '0)
                   && (res.clipped_end_x == '0) && (res.clipped_end_y == '0);

    `LSWC_ASSERT_NEXT(a_busy_after_beat, seg.valid && seg.ready, !seg.ready, "busy segment")
    `LSWC_ASSERT_NOW(a_reject_zero, res.valid && !res.visible, rej_zero, "reject not zeroed")
    `LSWC_ASSERT_NOW(a_result_after_work, $rose(res.valid), $past(!seg.ready), "idle result")

endmodule
